// ===== rtl/core/nmea_rmc_field_extractor_unit_defines.svh =====
// Assertion macros shared by the RMC field extractor RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMCFX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmcfx same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RMCFX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmcfx next-cycle check failed");

`endif

// ===== rtl/core/rmcfx_pkg.sv =====
// Shared types and constants of the RMC field extractor.
// No dependencies; the register, tracker and top-level RTL files import this package.
`default_nettype none

package rmcfx_pkg;

  // ASCII characters that steer the parse
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Field numbers inside the sentence (counted from 0 at the talker id)
  localparam logic [3:0] FIELD_TIME       = 4'd1;
  localparam logic [3:0] FIELD_LAT        = 4'd3;
  localparam logic [3:0] FIELD_LON        = 4'd5;
  localparam logic [3:0] FIELD_SPEED      = 4'd7;
  localparam logic [3:0] FIELD_DATE       = 4'd9;
  localparam logic [3:0] FIELD_AFTER_DATE = 4'd10;

  // Field tags on the result
  localparam logic [2:0] TAG_TIME  = 3'd0;
  localparam logic [2:0] TAG_LAT   = 3'd1;
  localparam logic [2:0] TAG_LON   = 3'd2;
  localparam logic [2:0] TAG_SPEED = 3'd3;
  localparam logic [2:0] TAG_DATE  = 3'd4;

  localparam logic [4:0] MIN_COORD_RESET = 5'd5;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       char_valid;
    logic [2:0] field_tag;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic       field_closed;
    logic [4:0] closed_length;
    logic       sentence_done;
    logic       position_valid;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rmcfx_ifs.sv =====
// Valid/ready channel interfaces of the RMC field extractor.
// Sentence bytes in, extracted characters out, and the threshold write port.
`default_nettype none

interface rmcfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface rmcfx_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [2:0] field_tag;
  logic [3:0] char_index;
  logic [7:0] char_value;
  logic       field_closed;
  logic [4:0] closed_length;
  logic       sentence_done;
  logic       position_valid;

  modport source (
    output valid, output char_valid, output field_tag, output char_index,
    output char_value, output field_closed, output closed_length,
    output sentence_done, output position_valid, input ready
  );
  modport sink (
    input valid, input char_valid, input field_tag, input char_index,
    input char_value, input field_closed, input closed_length,
    input sentence_done, input position_valid, output ready
  );
endinterface

interface rmcfx_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] min_coord_chars;

  modport source (output valid, output min_coord_chars, input ready);
  modport sink   (input valid, input min_coord_chars, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rmcfx_in_reg.sv =====
// Input register of the RMC field extractor: captures one sentence byte.
// Depends on rmcfx_pkg and rmcfx_in_if.
`default_nettype none

module rmcfx_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  rmcfx_in_if.sink            sentence,
  input  wire logic           advance,
  output logic                item_valid,
  output rmcfx_pkg::item_t    item
);
  import rmcfx_pkg::*;

  logic load;

  // free when empty or when the held item moves on this cycle
  assign sentence.ready = !item_valid || advance;
  assign load           = sentence.valid && sentence.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.byte_value <= sentence.byte_value;
      item.last_byte  <= sentence.last_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rmcfx_parse.sv =====
// Field tracker of the RMC field extractor: running counters and result logic.
// Depends on rmcfx_pkg, rmcfx_cfg_if and the assertion macro header.
`default_nettype none
`include "nmea_rmc_field_extractor_unit_defines.svh"

module rmcfx_parse #(
  parameter int BUFFER_BYTES = 128,
  parameter int FIELD_CHARS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  rmcfx_cfg_if.sink              cfg,
  input  wire logic              step,
  input  rmcfx_pkg::item_t       item,
  output rmcfx_pkg::result_t     result
);
  import rmcfx_pkg::*;

  localparam logic [7:0] BUF_LIMIT   = 8'(BUFFER_BYTES);
  localparam logic [4:0] COUNT_LIMIT = 5'(FIELD_CHARS);

  logic [4:0] min_coord_chars;
  logic [3:0] field_number,    field_number_next;
  logic [4:0] char_count,      char_count_next;
  logic       seen_dot,        seen_dot_next;
  logic       lat_long_enough, lat_long_enough_next;
  logic       lon_long_enough, lon_long_enough_next;
  logic [7:0] byte_position,   byte_position_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_coord_chars <= MIN_COORD_RESET;
    end else if (cfg.valid) begin
      min_coord_chars <= cfg.min_coord_chars;
    end
  end

  always_comb begin
    logic       in_bound;
    logic       is_comma;
    logic       kept;
    logic [2:0] tag;
    logic       lat_final;
    logic       lon_final;

    in_bound = byte_position < BUF_LIMIT;
    is_comma = in_bound && (item.byte_value == CH_COMMA);

    kept = 1'b1;
    unique case (field_number)
      FIELD_TIME:  tag = TAG_TIME;
      FIELD_LAT:   tag = TAG_LAT;
      FIELD_LON:   tag = TAG_LON;
      FIELD_SPEED: tag = TAG_SPEED;
      FIELD_DATE:  tag = TAG_DATE;
      default: begin
        tag  = TAG_TIME;
        kept = 1'b0;
      end
    endcase

    lat_final            = 1'b0;
    lon_final            = 1'b0;
    result               = '0;
    field_number_next    = field_number;
    char_count_next      = char_count;
    seen_dot_next        = seen_dot;
    lat_long_enough_next = lat_long_enough;
    lon_long_enough_next = lon_long_enough;
    byte_position_next   = byte_position;

    if (in_bound) begin
      byte_position_next = byte_position + 8'd1;
      if (is_comma) begin
        if (field_number < FIELD_AFTER_DATE) begin
          if (kept) begin
            result.field_closed  = 1'b1;
            result.closed_length = char_count;
            result.field_tag     = tag;
            if (field_number == FIELD_LAT) begin
              lat_long_enough_next = char_count >= min_coord_chars;
            end
            if (field_number == FIELD_LON) begin
              lon_long_enough_next = char_count >= min_coord_chars;
            end
          end
          field_number_next = field_number + 4'd1;
          char_count_next   = '0;
          seen_dot_next     = 1'b0;
        end
      end else if (kept) begin
        if (tag == TAG_TIME && item.byte_value == CH_DOT) begin
          seen_dot_next = 1'b1;
        end else if (!(tag == TAG_TIME && seen_dot) && char_count < COUNT_LIMIT) begin
          result.char_valid = 1'b1;
          result.field_tag  = tag;
          result.char_index = char_count[3:0];
          result.char_value = item.byte_value;
          char_count_next   = char_count + 5'd1;
        end
      end
    end

    if (item.last_byte) begin
      // close an open kept field at the end of the sentence
      if (!is_comma && kept) begin
        result.field_closed  = 1'b1;
        result.closed_length = char_count_next;
        result.field_tag     = tag;
      end
      lat_final = lat_long_enough_next;
      if (field_number_next < FIELD_LAT) begin
        lat_final = min_coord_chars == 5'd0;
      end else if (field_number_next == FIELD_LAT) begin
        lat_final = char_count_next >= min_coord_chars;
      end
      lon_final = lon_long_enough_next;
      if (field_number_next < FIELD_LON) begin
        lon_final = min_coord_chars == 5'd0;
      end else if (field_number_next == FIELD_LON) begin
        lon_final = char_count_next >= min_coord_chars;
      end
      result.sentence_done  = 1'b1;
      result.position_valid = lat_final && lon_final;
      field_number_next    = '0;
      char_count_next      = '0;
      seen_dot_next        = 1'b0;
      lat_long_enough_next = 1'b0;
      lon_long_enough_next = 1'b0;
      byte_position_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number    <= '0;
      char_count      <= '0;
      seen_dot        <= 1'b0;
      lat_long_enough <= 1'b0;
      lon_long_enough <= 1'b0;
      byte_position   <= '0;
    end else if (step) begin
      field_number    <= field_number_next;
      char_count      <= char_count_next;
      seen_dot        <= seen_dot_next;
      lat_long_enough <= lat_long_enough_next;
      lon_long_enough <= lon_long_enough_next;
      byte_position   <= byte_position_next;
    end
  end

  `RMCFX_ASSERT_NOW(a_count_bound, 1'b1, char_count <= COUNT_LIMIT)
  `RMCFX_ASSERT_NOW(a_emit_below_limit, step && result.char_valid, char_count < COUNT_LIMIT)
  `RMCFX_ASSERT_NEXT(a_clear_after_last, step && item.last_byte,
                     field_number == 4'd0 && char_count == 5'd0 && byte_position == 8'd0)
  `RMCFX_ASSERT_NEXT(a_hold_past_bound,
                     step && !item.last_byte && byte_position >= BUF_LIMIT,
                     $stable(field_number) && $stable(char_count))

endmodule

`default_nettype wire

// ===== rtl/core/rmcfx_out_reg.sv =====
// Result register of the RMC field extractor: holds one result item.
// Depends on rmcfx_pkg and rmcfx_out_if.
`default_nettype none

module rmcfx_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  rmcfx_pkg::result_t   result,
  output logic                 free,
  rmcfx_out_if.source          extract
);
  import rmcfx_pkg::*;

  logic    held_valid;
  result_t held;

  // room when empty or when the held item leaves this cycle
  assign free = !held_valid || extract.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (extract.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign extract.valid          = held_valid;
  assign extract.char_valid     = held.char_valid;
  assign extract.field_tag      = held.field_tag;
  assign extract.char_index     = held.char_index;
  assign extract.char_value     = held.char_value;
  assign extract.field_closed   = held.field_closed;
  assign extract.closed_length  = held.closed_length;
  assign extract.sentence_done  = held.sentence_done;
  assign extract.position_valid = held.position_valid;

endmodule

`default_nettype wire

// ===== rtl/core/nmea_rmc_field_extractor_unit.sv =====
// Top level of the RMC field extractor: input register, field tracker, result register.
// Depends on rmcfx_pkg, rmcfx_ifs, rmcfx_in_reg, rmcfx_parse and rmcfx_out_reg.
`default_nettype none

//  channel    direction  handshake     payload
//  sentence   sink       valid/ready   byte_value[7:0], last_byte
//  extract    source     valid/ready   char/field/sentence result fields
//  cfg        sink       valid/ready   min_coord_chars[4:0] (ready always high)
//
//  An accepted byte passes the input register and the field tracker into the result register.
//  One byte per cycle is sustained while extract is ready; the combinational field tracker sets this.
//  Synchronous reset clears the counters, the valid flags and sets the
//  threshold to 5; no clearing pass is needed.
//  A stall on extract holds the result register and then the input register;
//  sentence.ready drops only when both are full.

module nmea_rmc_field_extractor_unit #(
  parameter int BUFFER_BYTES = 128,
  parameter int FIELD_CHARS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rmcfx_in_if.sink    sentence,
  rmcfx_out_if.source extract,
  rmcfx_cfg_if.sink   cfg
);
  import rmcfx_pkg::*;

  logic    item_valid;
  item_t   item;
  result_t result;
  logic    out_free;
  logic    advance;

  // Move the held byte through the tracker when the result register has room.
  assign advance = item_valid && out_free;

  rmcfx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .sentence   (sentence),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Counters advance exactly once per item, in the same cycle the result loads.
  rmcfx_parse #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .FIELD_CHARS  (FIELD_CHARS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  rmcfx_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .result  (result),
    .free    (out_free),
    .extract (extract)
  );

endmodule

`default_nettype wire
